### rtl/fcrt_pkg.sv
// types, word map and fixed values of the four-channel reload timer register file
package fcrt_pkg;

    // item kinds carried on tuser
    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_TICK  = 2'd2
    } t_kind;

    // word map
    localparam logic [9:0] W_ID0     = 10'd0;
    localparam logic [9:0] W_ID1     = 10'd4;
    localparam logic [9:0] W_INTEN   = 10'd5;
    localparam logic [9:0] W_INTST   = 10'd6;
    localparam logic [9:0] W_CHEN    = 10'd7;
    localparam logic [9:0] W_RELOAD0 = 10'd9;
    localparam logic [9:0] W_COUNT0  = 10'd10;
    localparam int         CH_STRIDE = 4;

    localparam logic [31:0] ID0_VALUE = 32'h0303_1003;
    localparam logic [31:0] ID1_VALUE = 32'h0000_0002;
    localparam logic [15:0] W1C_MASK  = 16'hffff;

    // reload word as loaded into a counter, zero counts as one
    function automatic logic [31:0] reload_eff(input logic [31:0] r);
        reload_eff = (r == 32'd0) ? 32'd1 : r;
    endfunction

endpackage

### rtl/four_channel_reload_timer_regs.sv
// register file and counters of the four-channel reload timer
//
// usage
//   slave channel: one item per handshake. tuser holds the kind (bus read,
//   bus write, or a counting tick for one channel); tdata holds the word
//   index, the write data and the ticking channel.
//   master channel: one item back for every item taken, in order: the read
//   value (zero for writes and ticks) and the four interrupt levels as they
//   stand after the item.
//   path: an item taken is held in the read stage, where the register
//   file read is registered, then moves into the output register once
//   that is free, and is shown on the master side from there.
//   throughput: one item per cycle unless the master side stalls, bounded
//   by the single register file port (one write or one read per item).
//   reset: all words but ID0 and ID1, counters, enables and status read as
//   zero; a valid bit per word in the file means no clearing pass is needed.
//   stall: a stalled master side holds its item while one more item moves
//   into the read stage; tready drops only when both stages are full.
module four_channel_reload_timer_regs
    import fcrt_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int REG_WORDS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [9:0] word_index, [41:10] write_data, [43:42] tick_channel, rest zero
    input  logic [47:0] i_s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [31:0] read_data, [35:32] irq_lines, rest zero
    output logic [39:0] o_m_axis_tdata
);

    localparam int AW = $clog2(REG_WORDS);

    // incoming item fields
    t_kind       in_kind;
    logic [9:0]  in_word;
    logic [31:0] in_data;
    logic [1:0]  in_tick_ch;
    logic        acc;

    assign in_kind    = t_kind'(i_s_axis_tuser);
    assign in_word    = i_s_axis_tdata[9:0];
    assign in_data    = i_s_axis_tdata[41:10];
    assign in_tick_ch = i_s_axis_tdata[43:42];
    assign acc        = i_s_axis_tvalid && o_s_axis_tready;

    // general words live in a single-port style memory; the words the
    // datapath needs every cycle are held in flops beside it
    logic [31:0] r_mem [REG_WORDS];
    logic        r_mem_valid [REG_WORDS];
    logic [31:0] r_mem_rd;
    logic        r_mem_rd_ok;

    logic [31:0] r_inten, n_inten;
    logic [31:0] r_intst, n_intst;
    logic [31:0] r_chen,  n_chen;
    logic [31:0] r_reload [NUM_CHANNELS];
    logic [31:0] n_reload [NUM_CHANNELS];
    logic [31:0] r_cnt    [NUM_CHANNELS];
    logic [31:0] n_cnt    [NUM_CHANNELS];

    // read stage and output register
    logic        r_s1_valid;
    logic        r_s1_from_mem;
    logic [31:0] r_s1_fixed;
    logic [3:0]  r_s1_irq;
    logic        r_out_valid;
    logic [31:0] r_out_data;
    logic [3:0]  r_out_irq;

    logic        in_file;
    logic        mem_wr;
    logic        mem_rd;
    logic [AW-1:0] addr;
    logic [31:0] rd_fixed;
    logic        rd_from_mem;
    logic [3:0]  n_irq;
    logic [31:0] s1_data;
    logic        out_load;

    assign in_file = (in_word < 10'(REG_WORDS));
    assign addr    = in_word[AW-1:0];

    // interrupt status, enable and channel enable are kept only in flops
    assign mem_wr = acc && (in_kind == KIND_WRITE) && in_file
                    && (in_word != W_INTEN) && (in_word != W_INTST)
                    && (in_word != W_CHEN);

    // next state of the channel datapath
    always_comb begin
        n_inten  = r_inten;
        n_intst  = r_intst;
        n_chen   = r_chen;
        n_reload = r_reload;
        n_cnt    = r_cnt;
        if (acc) begin
            case (in_kind)
                KIND_WRITE: begin
                    if (in_word == W_INTST) begin
                        n_intst = r_intst & ~{16'd0, in_data[15:0] & W1C_MASK};
                    end else if (in_word == W_CHEN) begin
                        n_chen = in_data;
                        // rising enable loads the counter
                        for (int c = 0; c < NUM_CHANNELS; c++) begin
                            if (in_data[c] && !r_chen[c]) begin
                                n_cnt[c] = reload_eff(r_reload[c]);
                            end
                        end
                    end else if (in_word == W_INTEN) begin
                        n_inten = in_data;
                    end
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (in_word == 10'(W_RELOAD0 + 10'(CH_STRIDE * c))) begin
                            n_reload[c] = in_data;
                        end
                    end
                end
                KIND_TICK: begin
                    for (int c = 0; c < NUM_CHANNELS; c++) begin
                        if (in_tick_ch == 2'(c) && r_chen[c]) begin
                            if (r_cnt[c] > 32'd1) begin
                                n_cnt[c] = r_cnt[c] - 32'd1;
                            end else begin
                                // reached zero or was already zero
                                n_intst[CH_STRIDE * c] = 1'b1;
                                n_cnt[c] = reload_eff(r_reload[c]);
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // interrupt levels after the item
    always_comb begin
        n_irq = 4'd0;
        for (int c = 0; c < NUM_CHANNELS; c++) begin
            n_irq[c] = (|n_inten[CH_STRIDE * c +: 4]) && (|n_intst[CH_STRIDE * c +: 4]);
        end
    end

    // read source: fixed words, flops and live counters, else the file
    always_comb begin
        rd_fixed    = 32'd0;
        rd_from_mem = 1'b0;
        if (in_kind == KIND_READ) begin
            if (in_word == W_ID0) begin
                rd_fixed = ID0_VALUE;
            end else if (in_word == W_ID1) begin
                rd_fixed = ID1_VALUE;
            end else if (in_word == W_INTEN) begin
                rd_fixed = r_inten;
            end else if (in_word == W_INTST) begin
                rd_fixed = r_intst;
            end else if (in_word == W_CHEN) begin
                rd_fixed = r_chen;
            end else begin
                rd_from_mem = in_file;
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    if (in_word == 10'(W_COUNT0 + 10'(CH_STRIDE * c))) begin
                        rd_fixed    = r_cnt[c];
                        rd_from_mem = 1'b0;
                    end
                end
            end
        end
    end

    assign mem_rd = acc && rd_from_mem;

    // register file: one write or one read per item; a later item's read
    // always comes at a later edge than an earlier write, so no forwarding
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            r_mem[addr] <= in_data;
        end
        if (mem_rd) begin
            r_mem_rd    <= r_mem[addr];
            r_mem_rd_ok <= r_mem_valid[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < REG_WORDS; w++) begin
                r_mem_valid[w] <= 1'b0;
            end
        end else if (mem_wr) begin
            r_mem_valid[addr] <= 1'b1;
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inten <= 32'd0;
            r_intst <= 32'd0;
            r_chen  <= 32'd0;
            for (int c = 0; c < NUM_CHANNELS; c++) begin
                r_reload[c] <= 32'd0;
                r_cnt[c]    <= 32'd0;
            end
        end else begin
            r_inten  <= n_inten;
            r_intst  <= n_intst;
            r_chen   <= n_chen;
            r_reload <= n_reload;
            r_cnt    <= n_cnt;
        end
    end

    // read stage feeding the output register
    assign s1_data  = r_s1_from_mem ? (r_mem_rd_ok ? r_mem_rd : 32'd0) : r_s1_fixed;
    assign out_load = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_valid <= 1'b1;
            end else if (out_load) begin
                r_s1_valid <= 1'b0;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_from_mem <= rd_from_mem;
            r_s1_fixed    <= rd_fixed;
            r_s1_irq      <= n_irq;
        end
        if (out_load) begin
            r_out_data <= s1_data;
            r_out_irq  <= r_s1_irq;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'd0, r_out_irq, r_out_data};

`ifndef SYNTHESIS
    // status bits are only ever set by a tick
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && in_kind != KIND_TICK) |=> ((r_intst & ~$past(r_intst)) == 32'd0))
        else $error("status bit set by an item that is not a tick");

    // both stages full and master stalled: nothing may be taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !i_m_axis_tready) |-> !o_s_axis_tready)
        else $error("item taken while both stages are full");

    // a taken item always reaches the read stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> r_s1_valid)
        else $error("accepted item lost before the read stage");

    // a tick on an enabled channel never leaves its counter at zero
    generate
        for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cnt_chk
            assert property (@(posedge i_clk) disable iff (!i_rst_n)
                (acc && in_kind == KIND_TICK && in_tick_ch == 2'(g) && r_chen[g])
                    |=> (r_cnt[g] != 32'd0))
                else $error("counter left at zero after a tick");
        end
    endgenerate
`endif

endmodule

### verif/four_channel_reload_timer_regs_checker.sv
// checker for the reload timer register file: predicts each reply and compares it
module four_channel_reload_timer_regs_checker
    import fcrt_pkg::*;
#(
    parameter int NUM_CHANNELS = 4,
    parameter int REG_WORDS    = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    // [9:0] word_index, [41:10] write_data, [43:42] tick_channel, rest zero
    input  logic [47:0] i_s_tdata,
    // [1:0] kind
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    // [31:0] read_data, [35:32] irq_lines, rest zero
    input  logic [39:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_outstanding
);

    typedef struct packed {
        logic [31:0] read_data;
        logic [3:0]  irq_lines;
    } t_timer_reply;

    logic [31:0]  words [REG_WORDS];
    logic [31:0]  counts [4];
    t_timer_reply due_replies [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s, got %h, want %h", $time, what, got, want);
        o_fail_count++;
    endtask

    // counter value a channel loads, a zero reload word counts as one
    function automatic logic [31:0] reload_of(input int c);
        logic [31:0] r;
        r = words[W_RELOAD0 + CH_STRIDE * c];
        return (r == 32'd0) ? 32'd1 : r;
    endfunction

    task automatic advance_timer(input logic [1:0] kind, input logic [9:0] idx,
                                 input logic [31:0] data, input logic [1:0] ch,
                                 output t_timer_reply reply);
        logic [31:0] old_en;
        int          rel;
        reply.read_data = '0;
        reply.irq_lines = '0;
        rel = int'(idx) - int'(W_COUNT0);
        case (kind)
            KIND_READ: begin
                if (idx == W_ID0)
                    reply.read_data = ID0_VALUE;
                else if (idx == W_ID1)
                    reply.read_data = ID1_VALUE;
                else if (rel >= 0 && rel % CH_STRIDE == 0 && rel / CH_STRIDE < NUM_CHANNELS)
                    reply.read_data = counts[rel / CH_STRIDE];
                else if (idx < REG_WORDS)
                    reply.read_data = words[idx];
            end
            KIND_WRITE: begin
                if (idx == W_INTST) begin
                    words[W_INTST] &= ~(data & {16'd0, W1C_MASK});
                end else if (idx == W_CHEN) begin
                    old_en = words[W_CHEN];
                    words[W_CHEN] = data;
                    for (int c = 0; c < NUM_CHANNELS; c++)
                        if (data[c] && !old_en[c])
                            counts[c] = reload_of(c);
                end else if (idx < REG_WORDS) begin
                    words[idx] = data;
                end
            end
            KIND_TICK: begin
                if (ch < NUM_CHANNELS && words[W_CHEN][ch]) begin
                    if (counts[ch] != 32'd0)
                        counts[ch] -= 32'd1;
                    // expiry, or a counter already at zero
                    if (counts[ch] == 32'd0) begin
                        words[W_INTST][4 * ch] = 1'b1;
                        counts[ch] = reload_of(ch);
                    end
                end
            end
            default: ;
        endcase
        for (int c = 0; c < NUM_CHANNELS; c++)
            reply.irq_lines[c] = (|words[W_INTEN][4 * c +: 4]) &&
                                 (|words[W_INTST][4 * c +: 4]);
    endtask

    always @(posedge i_clk) begin
        t_timer_reply got, want;
        if (!i_rst_n) begin
            foreach (words[k]) words[k] = '0;
            foreach (counts[k]) counts[k] = '0;
            due_replies.delete();
            o_fail_count = 0;
        end else begin
            // replies leave before new items are predicted
            if (i_m_tvalid && i_m_tready) begin
                got = {i_m_tdata[31:0], i_m_tdata[35:32]};
                if (due_replies.size() == 0) begin
                    report_mismatch("unexpected reply", got.read_data, '0);
                end else begin
                    want = due_replies.pop_front();
                    if (got.read_data !== want.read_data)
                        report_mismatch("read_data", got.read_data, want.read_data);
                    if (got.irq_lines !== want.irq_lines)
                        report_mismatch("irq_lines", 32'(got.irq_lines),
                                        32'(want.irq_lines));
                    if (i_m_tdata[39:36] !== 4'd0)
                        report_mismatch("padding", 32'(i_m_tdata[39:36]), '0);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                advance_timer(i_s_tuser, i_s_tdata[9:0], i_s_tdata[41:10],
                              i_s_tdata[43:42], want);
                due_replies.push_back(want);
            end
        end
        o_outstanding <= due_replies.size();
    end

endmodule

### verif/four_channel_reload_timer_regs_tb.sv
// top of the reload timer register file testbench: stimulus, sink and verdict
module four_channel_reload_timer_regs_tb;
    import fcrt_pkg::*;

    localparam int NUM_CH      = 4;
    localparam int WORDS       = 64;
    localparam int RAND_ITEMS  = 500;
    localparam int HOLD_CYCLES = 60;
    // kind code the block leaves unused, it must change nothing
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [47:0] s_data = '0;   // [9:0] word_index, [41:10] write_data, [43:42] tick_channel
    logic [1:0]  s_user = '0;   // [1:0] kind
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [39:0] m_data;        // [31:0] read_data, [35:32] irq_lines

    // shared knobs, written with nonblocking assignments only
    logic gaps_on = 1'b1;       // random idling on both sides
    logic hold_req = 1'b0;      // ask the sink for its long hold-off
    logic hold_done = 1'b0;

    int fail_count;
    int outstanding;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    four_channel_reload_timer_regs #(
        .NUM_CHANNELS(NUM_CH),
        .REG_WORDS   (WORDS)
    ) dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (m_data)
    );

    four_channel_reload_timer_regs_checker #(
        .NUM_CHANNELS(NUM_CH),
        .REG_WORDS   (WORDS)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    // present one item, possibly after random idling, and wait for it to be taken;
    // tvalid stays high on return so back-to-back items need no second assignment
    task automatic offer_item(input logic [1:0] kind, input logic [9:0] idx,
                              input logic [31:0] data, input logic [1:0] ch);
        while (gaps_on && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= kind;
        s_data  <= {4'd0, ch, data, idx};
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
    endtask

    // wait until the checker holds no outstanding reply; the first edge lets the
    // count catch up with an item taken at the edge just gone
    task automatic drain_replies();
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // sink side: random back-pressure, plus one long hold-off counted here
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done <= 1'b1;
            end
            m_ready <= !(gaps_on && $urandom_range(99) < 9);
        end
    end

    // overall limit, far beyond the slowest correct run
    initial begin
        #3_000_000;
        $display("four_channel_reload_timer_regs_tb: done, errors");
        $finish;
    end

    initial begin : stimulus
        logic [1:0]  kind;
        logic [9:0]  idx;
        logic [31:0] data;
        logic [1:0]  ch;
        int          pick;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identification words, and words past the end of the file
        offer_item(KIND_READ, W_ID0, '0, 2'd0);
        offer_item(KIND_READ, W_ID1, '0, 2'd0);
        offer_item(KIND_WRITE, 10'h3ff, 32'hffff_ffff, 2'd3);
        offer_item(KIND_READ, 10'h3ff, '0, 2'd3);
        // fixed and live words keep reading their own value after a write
        offer_item(KIND_WRITE, W_ID0, 32'hffff_ffff, 2'd0);
        offer_item(KIND_READ, W_ID0, '0, 2'd0);
        offer_item(KIND_WRITE, W_COUNT0, 32'h1234_5678, 2'd0);
        offer_item(KIND_READ, W_COUNT0, '0, 2'd0);
        // reload words: small, zero (counts as one), all ones, two
        offer_item(KIND_WRITE, W_INTEN, 32'hffff_ffff, 2'd0);
        offer_item(KIND_WRITE, W_RELOAD0, 32'd3, 2'd0);
        offer_item(KIND_WRITE, 10'(W_RELOAD0 + CH_STRIDE), 32'd0, 2'd0);
        offer_item(KIND_WRITE, 10'(W_RELOAD0 + 2 * CH_STRIDE), 32'hffff_ffff, 2'd0);
        offer_item(KIND_WRITE, 10'(W_RELOAD0 + 3 * CH_STRIDE), 32'd2, 2'd0);
        // enable rising on all four channels loads the counters
        offer_item(KIND_WRITE, W_CHEN, 32'h0000_000f, 2'd0);
        offer_item(KIND_READ, W_COUNT0, '0, 2'd0);
        offer_item(KIND_READ, 10'(W_COUNT0 + CH_STRIDE), '0, 2'd0);
        // ticks: channels 0, 1 and 3 down to expiry, one tick on channel 2
        repeat (3) offer_item(KIND_TICK, '0, '0, 2'd0);
        offer_item(KIND_TICK, '0, '0, 2'd1);
        offer_item(KIND_TICK, '0, '0, 2'd2);
        repeat (2) offer_item(KIND_TICK, '0, '0, 2'd3);
        offer_item(KIND_READ, W_INTST, '0, 2'd0);
        offer_item(KIND_WRITE, W_INTST, 32'hffff_ffff, 2'd0);
        offer_item(KIND_UNUSED, W_CHEN, 32'hffff_ffff, 2'd2);
        // a tick on a disabled channel is dropped
        offer_item(KIND_WRITE, W_CHEN, 32'd0, 2'd0);
        offer_item(KIND_TICK, '0, '0, 2'd0);

        for (int n = 0; n < RAND_ITEMS; n++) begin
            // pressure points: long sink hold-off, a stretch with no idling, a full drain
            if (n == 100)
                hold_req <= 1'b1;
            if (n == 200)
                gaps_on <= 1'b0;
            if (n == 300)
                gaps_on <= 1'b1;
            if (n == 350) begin
                s_valid <= 1'b0;
                drain_replies();
            end

            pick = $urandom_range(99);
            if (pick < 40)
                kind = KIND_TICK;
            else if (pick < 70)
                kind = KIND_WRITE;
            else if (pick < 95)
                kind = KIND_READ;
            else
                kind = KIND_UNUSED;

            // mostly the mapped words, some plain words, a few beyond the file
            pick = $urandom_range(99);
            if (pick < 85)
                idx = 10'($urandom_range(23));
            else if (pick < 95)
                idx = 10'($urandom_range(WORDS - 1, 24));
            else
                idx = 10'($urandom_range(1023, WORDS));

            data = $urandom();
            // short reloads so that channels expire often
            if (idx >= W_RELOAD0 && idx < W_RELOAD0 + NUM_CH * CH_STRIDE &&
                (idx - W_RELOAD0) % CH_STRIDE == 0 && $urandom_range(99) < 80)
                data = 32'($urandom_range(6));
            ch = 2'($urandom_range(3));
            offer_item(kind, idx, data, ch);
        end
        s_valid <= 1'b0;

        drain_replies();
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("four_channel_reload_timer_regs_tb: done, clean");
        else
            $display("four_channel_reload_timer_regs_tb: done, errors");
        $finish;
    end

endmodule

### filelist.f
rtl/fcrt_pkg.sv
rtl/four_channel_reload_timer_regs.sv
verif/four_channel_reload_timer_regs_checker.sv
verif/four_channel_reload_timer_regs_tb.sv
